// ----- sv/dkps_pkg.sv -----
// Constants and types shared by the distance-keeping PID speed controller.
package dkps_pkg;

    // Default echo pulse width in bits.
    localparam int ECHO_WIDTH_DEF = 24;

    // Configuration register indexes.
    localparam logic [2:0] CFG_MIN_DIST  = 3'd0;
    localparam logic [2:0] CFG_MAX_SPEED = 3'd1;
    localparam logic [2:0] CFG_GAIN_P    = 3'd2;
    localparam logic [2:0] CFG_GAIN_I    = 3'd3;
    localparam logic [2:0] CFG_GAIN_D    = 3'd4;

    // Clamp outcome codes.
    typedef enum logic [1:0] {
        CLAMP_NONE  = 2'd0,
        CLAMP_UPPER = 2'd1,
        CLAMP_LOWER = 2'd2
    } clamp_t;

    // Register reset values.
    localparam logic [9:0]  MIN_DIST_RST  = 10'd30;
    localparam logic [6:0]  MAX_SPEED_RST = 7'd50;
    localparam logic [11:0] GAIN_P_RST    = 12'd850;
    localparam logic [11:0] GAIN_I_RST    = 12'd10;
    localparam logic [11:0] GAIN_D_RST    = 12'd25;

    // Speed limits.
    localparam logic [6:0]  SPEED_LIMIT  = 7'd100;
    localparam logic [7:0]  STOP_VALUE   = 8'd100;
    localparam logic [8:0]  MATCH_OFFSET = 9'd199;

    // Distance: floor(ticks / 4640) = floor((ticks >> 5) / 145), saturated at 4095.
    localparam logic [24:0] SAT_TICKS = 25'd19005440;   // 4096 * 4640
    localparam logic [24:0] DIV_MUL   = 25'd29620465;   // ceil(2^32 / 145)

    // Gain scale factors folded into the stored gains.
    localparam logic [9:0]  P_SCALE   = 10'd1000;
    localparam logic [16:0] D_SCALE   = 17'd100000;
    localparam logic [19:0] OUT_SCALE = 20'd1000000;

    // Quotient by 1e6 of a magnitude below 101e6: (mag >> 6) / 15625.
    localparam logic [17:0] QUO_MUL   = 18'd137439;     // ceil(2^31 / 15625)

    // Clamp threshold (limit + 1) * 1e6 for a limit value.
    function automatic logic [26:0] clamp_thr(input logic [6:0] lim);
        clamp_thr = 27'(lim + 7'd1) * 27'(OUT_SCALE);
    endfunction

    // Clamp an incoming speed limit to the allowed range.
    function automatic logic [6:0] limit_speed(input logic [6:0] val);
        limit_speed = (val > SPEED_LIMIT) ? SPEED_LIMIT : val;
    endfunction

endpackage

// ----- sv/distance_keeping_pid_speed.sv -----
// Distance-keeping PID speed controller with output clamp, top level.
//
//  channel  | direction | contents (lowest bit first)
//  ---------+-----------+--------------------------------------------------------
//  s_*      | in        | echo_ticks
//  m_*      | out       | distance_cm, speed_command, servo_match, clamp_state
//  cfg_*    | in        | write enable, register index, write data
//
// One request is taken every cycle while no rank is held by m_tready; each
// result passes through the six register ranks of the pipeline (input,
// distance, PID products, sum, divide-and-clamp, output).
// Reset is asynchronous and clears all valid flags, the error/integral state
// and the configuration to its defaults.
// Each rank holds only when the rank after it is full and blocked, so bubbles
// close up and requests are still taken while a result waits on m_tready.
module distance_keeping_pid_speed #(
    parameter int ECHO_WIDTH = dkps_pkg::ECHO_WIDTH_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,

    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // [ECHO_WIDTH-1:0] echo_ticks, zero padding above
    input  logic [((ECHO_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,

    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // [11:0] distance_cm, [19:12] speed_command, [28:20] servo_match,
    // [30:29] clamp_state, [31] zero
    output logic [31:0]                             m_tdata,

    input  logic                                    cfg_we,
    input  logic [2:0]                              cfg_index,
    input  logic [11:0]                             cfg_wdata
);

    // Width used for the distance computation; the divider reads bits up to 24.
    localparam int TW = (ECHO_WIDTH > 25) ? ECHO_WIDTH : 25;

    // ------------------------------------------------------------------
    // Configuration registers. Gains are stored pre-scaled so that the
    // PID stage needs one multiplier per term.
    // ------------------------------------------------------------------
    logic [9:0]  min_dist_reg;
    logic [6:0]  lim_reg;
    logic [26:0] thr_reg;
    logic [21:0] gp1000_reg;
    logic [11:0] gi_reg;
    logic [28:0] gd1e5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_dist_reg <= dkps_pkg::MIN_DIST_RST;
            lim_reg      <= dkps_pkg::MAX_SPEED_RST;
            thr_reg      <= dkps_pkg::clamp_thr(dkps_pkg::MAX_SPEED_RST);
            gp1000_reg   <= 22'(dkps_pkg::GAIN_P_RST) * 22'(dkps_pkg::P_SCALE);
            gi_reg       <= dkps_pkg::GAIN_I_RST;
            gd1e5_reg    <= 29'(dkps_pkg::GAIN_D_RST) * 29'(dkps_pkg::D_SCALE);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dkps_pkg::CFG_MIN_DIST:
                begin
                    min_dist_reg <= cfg_wdata[9:0];
                end
                dkps_pkg::CFG_MAX_SPEED:
                begin
                    lim_reg <= dkps_pkg::limit_speed(cfg_wdata[6:0]);
                    thr_reg <= dkps_pkg::clamp_thr(dkps_pkg::limit_speed(cfg_wdata[6:0]));
                end
                dkps_pkg::CFG_GAIN_P:
                begin
                    gp1000_reg <= 22'(cfg_wdata) * 22'(dkps_pkg::P_SCALE);
                end
                dkps_pkg::CFG_GAIN_I:
                begin
                    gi_reg <= cfg_wdata;
                end
                dkps_pkg::CFG_GAIN_D:
                begin
                    gd1e5_reg <= 29'(cfg_wdata) * 29'(dkps_pkg::D_SCALE);
                end
                default:
                begin
                    // Index past the register list: drop the write.
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a rank loads when it is empty or the rank
    // after it is loading.
    // ------------------------------------------------------------------
    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg, e_valid_reg, o_valid_reg;
    logic a_ready, b_ready, c_ready, d_ready, e_ready, o_ready;

    assign o_ready  = !o_valid_reg || m_tready;
    assign e_ready  = !e_valid_reg || o_ready;
    assign d_ready  = !d_valid_reg || e_ready;
    assign c_ready  = !c_valid_reg || d_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign s_tready = a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready) a_valid_reg <= s_tvalid;
            if (b_ready) b_valid_reg <= a_valid_reg;
            if (c_ready) c_valid_reg <= b_valid_reg;
            if (d_ready) d_valid_reg <= c_valid_reg;
            if (e_ready) e_valid_reg <= d_valid_reg;
            if (o_ready) o_valid_reg <= e_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Rank A: input register.
    // ------------------------------------------------------------------
    logic [ECHO_WIDTH-1:0] a_ticks_reg;

    always_ff @(posedge clk)
    begin
        if (a_ready && s_tvalid)
            a_ticks_reg <= s_tdata[ECHO_WIDTH-1:0];
    end

    // ------------------------------------------------------------------
    // Rank B: distance = floor(ticks / 4640), saturated at 4095.
    // Below the saturation point ticks >> 5 fits 20 bits, where the
    // reciprocal multiply by ceil(2^32/145) is exact.
    // ------------------------------------------------------------------
    logic [TW-1:0] ticks_ext;
    logic          dist_sat;
    logic [19:0]   div_x;
    logic [44:0]   div_prod;
    logic [11:0]   b_dist_next;
    logic [11:0]   b_dist_reg;

    always_comb
    begin
        ticks_ext   = TW'(a_ticks_reg);
        dist_sat    = ticks_ext >= TW'(dkps_pkg::SAT_TICKS);
        div_x       = ticks_ext[24:5];
        div_prod    = 45'(div_x) * 45'(dkps_pkg::DIV_MUL);
        b_dist_next = dist_sat ? 12'hFFF : div_prod[43:32];
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
            b_dist_reg <= b_dist_next;
    end

    // ------------------------------------------------------------------
    // Rank C: error, derivative, saturating integral and the three gain
    // products. The loop state advances when the item leaves rank B.
    // ------------------------------------------------------------------
    logic signed [12:0] prev_err_reg;
    logic signed [31:0] integ_reg;

    logic signed [12:0] err;
    logic signed [13:0] derr;
    logic signed [16:0] err10;
    logic signed [33:0] integ_sum;
    logic signed [31:0] integ_next;
    logic signed [35:0] c_pp_next;
    logic signed [44:0] c_pi_next;
    logic signed [43:0] c_pd_next;

    logic [11:0]        c_dist_reg;
    logic signed [35:0] c_pp_reg;
    logic signed [44:0] c_pi_reg;
    logic signed [43:0] c_pd_reg;

    always_comb
    begin
        err       = $signed({3'b000, min_dist_reg}) - $signed({1'b0, b_dist_reg});
        derr      = $signed({err[12], err}) - $signed({prev_err_reg[12], prev_err_reg});
        err10     = $signed({{4{err[12]}}, err}) * 17'sd10;
        integ_sum = $signed({{2{integ_reg[31]}}, integ_reg})
                  + $signed({{17{err10[16]}}, err10});
        // Saturate at the signed 32-bit limits.
        if (integ_sum[33:31] == 3'b000 || integ_sum[33:31] == 3'b111)
            integ_next = integ_sum[31:0];
        else if (integ_sum[33])
            integ_next = 32'sh8000_0000;
        else
            integ_next = 32'sh7FFF_FFFF;
        c_pp_next = $signed({1'b0, gp1000_reg}) * err;
        c_pi_next = $signed({1'b0, gi_reg}) * integ_next;
        c_pd_next = $signed({1'b0, gd1e5_reg}) * derr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_err_reg <= '0;
            integ_reg    <= '0;
        end
        else if (c_ready && b_valid_reg)
        begin
            prev_err_reg <= err;
            integ_reg    <= integ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_ready && b_valid_reg)
        begin
            c_dist_reg <= b_dist_reg;
            c_pp_reg   <= c_pp_next;
            c_pi_reg   <= c_pi_next;
            c_pd_reg   <= c_pd_next;
        end
    end

    // ------------------------------------------------------------------
    // Rank D: sum the PID terms. The total stays inside 45 signed bits.
    // ------------------------------------------------------------------
    logic signed [44:0] d_acc_next;
    logic signed [44:0] d_acc_reg;
    logic [11:0]        d_dist_reg;

    assign d_acc_next = $signed({{9{c_pp_reg[35]}}, c_pp_reg}) + c_pi_reg
                      + $signed({c_pd_reg[43], c_pd_reg});

    always_ff @(posedge clk)
    begin
        if (d_ready && c_valid_reg)
        begin
            d_dist_reg <= c_dist_reg;
            d_acc_reg  <= d_acc_next;
        end
    end

    // ------------------------------------------------------------------
    // Rank E: clamp decision against (limit+1)*1e6, and the truncated
    // quotient by 1e6 for the in-range case, where |acc| < 101e6.
    // ------------------------------------------------------------------
    logic signed [44:0] thr_s;
    logic               hit_upper;
    logic               hit_lower;
    logic [44:0]        mag;
    logic [20:0]        quo_x;
    logic [38:0]        quo_prod;
    dkps_pkg::clamp_t   e_cls_next;

    logic [11:0]        e_dist_reg;
    dkps_pkg::clamp_t   e_cls_reg;
    logic [6:0]         e_quo_reg;
    logic               e_neg_reg;

    always_comb
    begin
        thr_s     = $signed({18'b0, thr_reg});
        hit_upper = d_acc_reg >= thr_s;
        hit_lower = d_acc_reg <= -thr_s;
        mag       = d_acc_reg[44] ? 45'(-d_acc_reg) : 45'(d_acc_reg);
        quo_x     = mag[26:6];
        quo_prod  = 39'(quo_x) * 39'(dkps_pkg::QUO_MUL);
        if (hit_upper)
            e_cls_next = dkps_pkg::CLAMP_UPPER;
        else if (hit_lower)
            e_cls_next = dkps_pkg::CLAMP_LOWER;
        else
            e_cls_next = dkps_pkg::CLAMP_NONE;
    end

    always_ff @(posedge clk)
    begin
        if (e_ready && d_valid_reg)
        begin
            e_dist_reg <= d_dist_reg;
            e_cls_reg  <= e_cls_next;
            e_quo_reg  <= quo_prod[37:31];
            e_neg_reg  <= d_acc_reg[44];
        end
    end

    // ------------------------------------------------------------------
    // Output rank: speed command around the stop value and servo match.
    // ------------------------------------------------------------------
    logic [7:0]       cmd_next;
    logic [8:0]       servo_next;

    logic [11:0]      o_dist_reg;
    logic [7:0]       o_cmd_reg;
    logic [8:0]       o_servo_reg;
    dkps_pkg::clamp_t o_cls_reg;

    always_comb
    begin
        case (e_cls_reg)
            dkps_pkg::CLAMP_UPPER: cmd_next = dkps_pkg::STOP_VALUE - {1'b0, lim_reg};
            dkps_pkg::CLAMP_LOWER: cmd_next = dkps_pkg::STOP_VALUE + {1'b0, lim_reg};
            default:
            begin
                if (e_neg_reg)
                    cmd_next = dkps_pkg::STOP_VALUE + {1'b0, e_quo_reg};
                else
                    cmd_next = dkps_pkg::STOP_VALUE - {1'b0, e_quo_reg};
            end
        endcase
        servo_next = {1'b0, cmd_next} + dkps_pkg::MATCH_OFFSET;
    end

    always_ff @(posedge clk)
    begin
        if (o_ready && e_valid_reg)
        begin
            o_dist_reg  <= e_dist_reg;
            o_cmd_reg   <= cmd_next;
            o_servo_reg <= servo_next;
            o_cls_reg   <= e_cls_reg;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = {1'b0, o_cls_reg, o_servo_reg, o_cmd_reg, o_dist_reg};

endmodule

// ----- dv/distance_keeping_pid_speed_tb.sv -----
// Self-checking testbench for the distance-keeping PID speed controller.
`timescale 1ns / 100ps

module distance_keeping_pid_speed_tb;

    localparam int ECHO_W       = dkps_pkg::ECHO_WIDTH_DEF;
    localparam int TDATA_W      = ((ECHO_W + 7) / 8) * 8;
    localparam int TICKS_PER_CM = 4640;
    localparam int DIST_SAT     = 4095;
    // Largest distance a full-scale echo can give at this echo width.
    localparam int DIST_TOP     = ((2 ** ECHO_W) - 1) / TICKS_PER_CM;
    localparam int INT_HI       = 32'sh7FFF_FFFF;
    localparam int INT_LO       = -INT_HI - 1;
    // Pipeline is six ranks deep; wait a little longer before touching registers.
    localparam int DRAIN_CYCLES = 8;

    // One expected result, field by field.
    typedef struct packed {
        logic [11:0]      distance;
        logic [7:0]       command;
        logic [8:0]       match;
        dkps_pkg::clamp_t clamp;
    } speed_result_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata   = '0;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [31:0]        m_tdata;
    logic               cfg_we    = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [11:0]        cfg_wdata = '0;

    // Mirror of the configuration registers, kept in step with every write.
    int min_dist_m  = int'(dkps_pkg::MIN_DIST_RST);
    int max_speed_m = int'(dkps_pkg::MAX_SPEED_RST);
    int gain_p_m    = int'(dkps_pkg::GAIN_P_RST);
    int gain_i_m    = int'(dkps_pkg::GAIN_I_RST);
    int gain_d_m    = int'(dkps_pkg::GAIN_D_RST);

    // Mirror of the controller state: last error and saturating integral.
    int prev_err_m  = 0;
    int integ_acc   = 0;

    // Expected results, oldest first, one per accepted request.
    speed_result_t pending_cmds[$];
    speed_result_t oldest;

    int src_idle_pct    = 0;
    int dst_stall_pct   = 0;
    int mismatches      = 0;
    int echo_count      = 0;
    int results_checked = 0;
    int settings_used   = 0;
    int clamp_seen[3]   = '{0, 0, 0};

    distance_keeping_pid_speed #(
        .ECHO_WIDTH (ECHO_W)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Advance the controller by one echo: convert to distance, update the
    // integral and last error, form the PID sum and clamp around the stop value.
    function automatic speed_result_t pid_speed_step(input logic [ECHO_W-1:0] ticks);
        speed_result_t r;
        longint dist_cm, err, derr, integ, acc, raw, lim, cmd, mtch;
        dist_cm = longint'(ticks) / TICKS_PER_CM;
        if (dist_cm > DIST_SAT)
            dist_cm = DIST_SAT;
        err   = longint'(min_dist_m) - dist_cm;
        derr  = err - longint'(prev_err_m);
        integ = longint'(integ_acc) + 10 * err;
        if (integ > INT_HI)
            integ = INT_HI;
        if (integ < INT_LO)
            integ = INT_LO;
        acc = longint'(gain_p_m) * 64'sd1000 * err
            + longint'(gain_i_m) * integ
            + longint'(gain_d_m) * 64'sd100000 * derr;
        // Signed division truncates toward zero.
        raw = acc / 64'sd1000000;
        prev_err_m = int'(err);
        integ_acc  = int'(integ);
        // A limit register above the legal range acts as the full range.
        lim = (max_speed_m > int'(dkps_pkg::SPEED_LIMIT)) ?
              longint'(dkps_pkg::SPEED_LIMIT) : longint'(max_speed_m);
        if (raw > lim)
        begin
            cmd     = longint'(dkps_pkg::STOP_VALUE) - lim;
            r.clamp = dkps_pkg::CLAMP_UPPER;
        end
        else if (raw < -lim)
        begin
            cmd     = longint'(dkps_pkg::STOP_VALUE) + lim;
            r.clamp = dkps_pkg::CLAMP_LOWER;
        end
        else
        begin
            cmd     = longint'(dkps_pkg::STOP_VALUE) - raw;
            r.clamp = dkps_pkg::CLAMP_NONE;
        end
        mtch       = cmd + longint'(dkps_pkg::MATCH_OFFSET);
        r.distance = dist_cm[11:0];
        r.command  = cmd[7:0];
        r.match    = mtch[8:0];
        return r;
    endfunction

    // Write one register and mirror it; bits above the register width are dropped
    // and an index past the register list leaves everything as it was.
    task automatic write_reg(input logic [2:0] idx, input logic [11:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            dkps_pkg::CFG_MIN_DIST:  min_dist_m  = int'(data[9:0]);
            dkps_pkg::CFG_MAX_SPEED: max_speed_m = int'(data[6:0]);
            dkps_pkg::CFG_GAIN_P:    gain_p_m    = int'(data);
            dkps_pkg::CFG_GAIN_I:    gain_i_m    = int'(data);
            dkps_pkg::CFG_GAIN_D:    gain_d_m    = int'(data);
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Drop the request line, wait for every expected result, then let the
    // pipeline run empty before anything else happens.
    task automatic settle_pipeline();
        s_tvalid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Load all five registers once the block has gone idle.
    task automatic program_regs(input logic [11:0] md, input logic [11:0] ms,
                                input logic [11:0] gp, input logic [11:0] gi,
                                input logic [11:0] gd);
        settle_pipeline();
        write_reg(dkps_pkg::CFG_MIN_DIST, md);
        write_reg(dkps_pkg::CFG_MAX_SPEED, ms);
        write_reg(dkps_pkg::CFG_GAIN_P, gp);
        write_reg(dkps_pkg::CFG_GAIN_I, gi);
        write_reg(dkps_pkg::CFG_GAIN_D, gd);
        settings_used++;
    endtask

    // Offer one echo request, with random idle cycles ahead of it, and hold it
    // until accepted. Called and returning right after a rising edge.
    task automatic send_echo(input logic [ECHO_W-1:0] ticks);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'(ticks);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_cmds.push_back(pid_speed_step(ticks));
        echo_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Result side: compare each accepted result with the oldest expectation,
    // then pick m_tready for the next cycle.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_cmds.size() == 0)
            begin
                $display("%0t: result with no request outstanding, expected none, actual %h",
                         $time, m_tdata);
                mismatches++;
            end
            else
            begin
                oldest = pending_cmds.pop_front();
                check_field("distance_cm", 16'(oldest.distance), 16'(m_tdata[11:0]));
                check_field("speed_command", 16'(oldest.command), 16'(m_tdata[19:12]));
                check_field("servo_match", 16'(oldest.match), 16'(m_tdata[28:20]));
                check_field("clamp_state", 16'(oldest.clamp), 16'(m_tdata[30:29]));
                clamp_seen[oldest.clamp]++;
                results_checked++;
            end
        end
        m_tready <= ($urandom_range(99) >= dst_stall_pct);
    end

    // Reset values: hard upper clamp, distance bucket edges, on-target, lower
    // clamp at full-scale echo, alternating bit patterns.
    task automatic test_defaults();
        src_idle_pct  = 0;
        dst_stall_pct = 0;
        send_echo(24'd0);
        send_echo(24'd4639);        // last tick of 0 cm
        send_echo(24'd4640);        // first tick of 1 cm
        send_echo(24'd139200);      // exactly on the 30 cm target
        send_echo(24'd139200);
        send_echo(24'd139199);
        send_echo(24'hAAAAAA);
        send_echo(24'h555555);
        send_echo(24'hFFFFFF);
    endtask

    // Register extremes, masking of wide writes and writes to unused indexes.
    task automatic test_register_edges();
        // Every gain zero: the command must sit at stop whatever the distance.
        program_regs(12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
        send_echo(24'd0);
        send_echo(24'hFFFFFF);
        // All ones: upper bits drop, min distance 1023, limit 127 acts as 100.
        program_regs(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
        send_echo(24'd0);
        send_echo(24'd4746720);     // on the 1023 cm target
        send_echo(24'hFFFFFF);
        // Zero limit: only a raw value of exactly zero escapes the clamp.
        program_regs(12'd500, 12'd0, 12'd4000, 12'd0, 12'd0);
        send_echo(24'd2320000);     // on target, raw zero
        send_echo(24'd0);
        send_echo(24'hFFFFFF);
        // Widest legal limit with a tiny gain: small raw values pass through.
        program_regs(12'd500, 12'd100, 12'd1, 12'd0, 12'd0);
        send_echo(24'hFFFFFF);
        send_echo(24'd0);
        // Writes past the register list must change nothing.
        settle_pipeline();
        for (int k = int'(dkps_pkg::CFG_GAIN_D) + 1; k < 8; k++)
            write_reg(3'(k), 12'hFFF);
        send_echo(24'hFFFFFF);
        send_echo(24'd0);
    endtask

    // Random echoes, mostly near the target so the loop stays in its linear
    // range, under random settings and each idle/stall pattern in turn.
    task automatic test_random_traffic();
        int src_pct[4] = '{0, 86, 0, 30};
        int dst_pct[4] = '{0, 0, 86, 30};
        logic [11:0] md, ms, gp, gi, gd;
        logic [ECHO_W-1:0] ticks;
        int pick, near_cm;
        for (int ph = 0; ph < 4; ph++)
        begin
            for (int s = 0; s < 2; s++)
            begin
                pick = $urandom_range(9);
                md = (pick < 2) ? 12'd0 : (pick < 4) ? 12'd1023 : 12'($urandom_range(1023));
                md[11:10] = 2'($urandom);
                pick = $urandom_range(9);
                ms = (pick < 2) ? 12'd0 : (pick < 4) ? 12'd100 : 12'($urandom_range(127));
                ms[11:7] = 5'($urandom);
                pick = $urandom_range(9);
                gp = (pick < 5) ? 12'($urandom_range(1000)) : 12'($urandom);
                pick = $urandom_range(9);
                gi = (pick < 5) ? 12'($urandom_range(3)) :
                     (pick < 8) ? 12'($urandom_range(100)) : 12'($urandom);
                pick = $urandom_range(9);
                gd = (pick < 7) ? 12'($urandom_range(40)) : 12'($urandom);
                program_regs(md, ms, gp, gi, gd);
                src_idle_pct  = src_pct[ph];
                dst_stall_pct = dst_pct[ph];
                repeat (210)
                begin
                    pick = $urandom_range(9);
                    if (pick < 8)
                    begin
                        // Hold within 40 cm of the target, random tick inside the bucket.
                        near_cm = min_dist_m + int'($urandom_range(80)) - 40;
                        if (near_cm < 0)
                            near_cm = 0;
                        ticks = ECHO_W'(near_cm * TICKS_PER_CM
                                        + int'($urandom_range(TICKS_PER_CM - 1)));
                    end
                    else
                        ticks = ECHO_W'($urandom);
                    send_echo(ticks);
                end
            end
        end
    endtask

    // Hold a large error one way and then the other at full rate, so the
    // integral term swings far from zero and back through it.
    task automatic test_integral_limits();
        src_idle_pct  = 0;
        dst_stall_pct = 0;
        program_regs(12'd1023, 12'd100, 12'd500, 12'd1, 12'd25);
        repeat (30) send_echo(ECHO_W'($urandom_range(TICKS_PER_CM - 1)));
        program_regs(12'd0, 12'd100, 12'd500, 12'd1, 12'd25);
        repeat (30) send_echo(ECHO_W'($urandom_range((2 ** ECHO_W) - 1,
                                                     DIST_TOP * TICKS_PER_CM)));
    endtask

    initial
    begin
        // Hold reset, then release it on an edge.
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults();
        test_register_edges();
        test_random_traffic();
        test_integral_limits();

        // Drain, then give stray results a chance to show up.
        settle_pipeline();
        repeat (20) @(posedge clk);

        $display("Run covered %0d echo requests under %0d register settings; %0d results checked.",
                 echo_count, settings_used, results_checked);
        $display("Clamp outcomes: within %0d, upper %0d, lower %0d; integral swung both ways.",
                 clamp_seen[dkps_pkg::CLAMP_NONE], clamp_seen[dkps_pkg::CLAMP_UPPER],
                 clamp_seen[dkps_pkg::CLAMP_LOWER]);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog: well beyond the slowest legal run.
    initial
    begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/dkps_pkg.sv
sv/distance_keeping_pid_speed.sv
dv/distance_keeping_pid_speed_tb.sv
